/* rtl/core/tcc_pkg.sv */
// Shared constants and status codes for the triangle circumcenter unit.
package tcc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_BITS       = 48;
    localparam int STATUS_BITS    = 2;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK        = 2'd0,
        STAT_COLLINEAR = 2'd1,
        STAT_SAT       = 2'd2
    } status_t;

endpackage

/* rtl/core/triangle_circumcenter_unit.sv */
// Triangle circumcenter unit: pipelined exact-integer circumcenter with restoring divider.
//
// Takes three points (a, b, c) with signed COORD_BITS-bit coordinates and returns the
// center of their circumscribed circle as signed fixed point, 48 bits wide with
// FRAC_BITS fraction bits, rounded to nearest with ties away from zero. Collinear points
// give zero coordinates with status COLLINEAR; a coordinate that does not fit in 48 bits
// is clamped to the nearest limit and the item carries status SAT. The block holds no
// state between items and takes one item every clock cycle while the skid register
// is empty. Each accepted item passes through one input register, three stages
// for squares/differences, products and sums, one stage that forms the dividend and the
// overflow check, one stage per quotient bit of the 48-stage restoring divider (one for
// x and one for y, side by side), one stage for sign and clamping, and the output
// register. Items flow through the pipeline under one shared enable; a skid register at
// the output absorbs the item in flight when m_tready drops, so s_tready goes low only
// once the skid register is full and no item is lost or repeated.
module triangle_circumcenter_unit #(
    parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tcc_pkg::FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y from the lowest bit up, zero padded to bytes
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]           s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // center_x, center_y from the lowest bit up
    output logic [2*tcc_pkg::OUT_BITS-1:0]              m_tdata,
    // status
    output logic [tcc_pkg::STATUS_BITS-1:0]             m_tuser
);

    localparam int CB   = COORD_BITS;
    localparam int QB   = tcc_pkg::OUT_BITS;
    localparam int DFW  = CB + 1;            // coordinate difference
    localparam int LSW  = 2*CB + 1;          // squared length, signed
    localparam int PW   = LSW + DFW;         // numerator partial product
    localparam int NW   = PW + 2;            // numerator
    localparam int DPW  = CB + DFW;          // denominator partial product
    localparam int DW   = DPW + 3;           // denominator (doubled)
    localparam int VW   = DW + 1;            // divisor 2|D|
    localparam int MW   = NW + FRAC_BITS + 2; // dividend 2|N|2^F + |D|
    localparam int HW   = (MW > QB) ? (MW - QB) : 1;
    localparam int CW   = (HW > VW) ? HW : VW;

    typedef struct packed {
        logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
    } coord_t;

    typedef struct packed {
        logic signed [LSW-1:0] la, lb, lc;
        logic signed [DFW-1:0] dy_bc, dy_ca, dy_ab, dx_cb, dx_ac, dx_ba;
        logic signed [CB-1:0]  ax, bx, cx;
    } diff_t;

    typedef struct packed {
        logic signed [PW-1:0]  nx0, nx1, nx2, ny0, ny1, ny2;
        logic signed [DPW-1:0] dp0, dp1, dp2;
    } prod_t;

    typedef struct packed {
        logic signed [NW-1:0] nx, ny;
        logic signed [DW-1:0] den;
    } sum_t;

    typedef struct packed {
        logic          zero;
        logic [VW-1:0] dvs;
        logic [VW-1:0] rx, ry;
        logic [QB-1:0] wx, wy;   // dividend low bits shifting out, quotient bits shifting in
        logic          negx, negy, ovfx, ovfy;
    } dstage_t;

    typedef struct packed {
        logic [QB-1:0]   cxo, cyo;
        tcc_pkg::status_t st;
    } res_t;

    function automatic dstage_t div_step(dstage_t s);
        logic [VW:0] t_x, t_y;
        dstage_t     o;
        o   = s;
        t_x = {s.rx, s.wx[QB-1]};
        t_y = {s.ry, s.wy[QB-1]};
        if (t_x >= {1'b0, s.dvs})
        begin
            o.rx = VW'(t_x - {1'b0, s.dvs});
            o.wx = {s.wx[QB-2:0], 1'b1};
        end
        else
        begin
            o.rx = t_x[VW-1:0];
            o.wx = {s.wx[QB-2:0], 1'b0};
        end
        if (t_y >= {1'b0, s.dvs})
        begin
            o.ry = VW'(t_y - {1'b0, s.dvs});
            o.wy = {s.wy[QB-2:0], 1'b1};
        end
        else
        begin
            o.ry = t_y[VW-1:0];
            o.wy = {s.wy[QB-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [QB-1:0] finish(logic [QB-1:0] q, logic neg, logic ovf,
                                             output logic sat);
        logic [QB-1:0] v;
        sat = ovf | (neg ? (q[QB-1] & (|q[QB-2:0])) : q[QB-1]);
        if (sat)
            v = neg ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
        else
            v = neg ? (~q + 1'b1) : q;
        return v;
    endfunction

    // pipeline enable: everything moves unless the skid register holds an item
    logic ce;
    logic skid_valid_reg;
    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    // ---------------- input register
    coord_t in_reg, in_next;
    logic   in_vld_reg;

    always_comb
    begin
        in_next.ax = s_tdata[0*CB +: CB];
        in_next.ay = s_tdata[1*CB +: CB];
        in_next.bx = s_tdata[2*CB +: CB];
        in_next.by = s_tdata[3*CB +: CB];
        in_next.cx = s_tdata[4*CB +: CB];
        in_next.cy = s_tdata[5*CB +: CB];
    end

    // ---------------- stage 1: squared lengths and differences
    diff_t s1_reg, s1_next;
    logic  s1_vld_reg;

    always_comb
    begin
        s1_next.la    = in_reg.ax * in_reg.ax + in_reg.ay * in_reg.ay;
        s1_next.lb    = in_reg.bx * in_reg.bx + in_reg.by * in_reg.by;
        s1_next.lc    = in_reg.cx * in_reg.cx + in_reg.cy * in_reg.cy;
        s1_next.dy_bc = in_reg.by - in_reg.cy;
        s1_next.dy_ca = in_reg.cy - in_reg.ay;
        s1_next.dy_ab = in_reg.ay - in_reg.by;
        s1_next.dx_cb = in_reg.cx - in_reg.bx;
        s1_next.dx_ac = in_reg.ax - in_reg.cx;
        s1_next.dx_ba = in_reg.bx - in_reg.ax;
        s1_next.ax    = in_reg.ax;
        s1_next.bx    = in_reg.bx;
        s1_next.cx    = in_reg.cx;
    end

    // ---------------- stage 2: products
    prod_t s2_reg, s2_next;
    logic  s2_vld_reg;

    always_comb
    begin
        s2_next.nx0 = s1_reg.la * s1_reg.dy_bc;
        s2_next.nx1 = s1_reg.lb * s1_reg.dy_ca;
        s2_next.nx2 = s1_reg.lc * s1_reg.dy_ab;
        s2_next.ny0 = s1_reg.la * s1_reg.dx_cb;
        s2_next.ny1 = s1_reg.lb * s1_reg.dx_ac;
        s2_next.ny2 = s1_reg.lc * s1_reg.dx_ba;
        s2_next.dp0 = s1_reg.ax * s1_reg.dy_bc;
        s2_next.dp1 = s1_reg.bx * s1_reg.dy_ca;
        s2_next.dp2 = s1_reg.cx * s1_reg.dy_ab;
    end

    // ---------------- stage 3: numerators and denominator
    sum_t s3_reg, s3_next;
    logic s3_vld_reg;
    logic signed [DW-2:0] dsum;

    always_comb
    begin
        s3_next.nx  = s2_reg.nx0 + s2_reg.nx1 + s2_reg.nx2;
        s3_next.ny  = s2_reg.ny0 + s2_reg.ny1 + s2_reg.ny2;
        dsum        = s2_reg.dp0 + s2_reg.dp1 + s2_reg.dp2;
        s3_next.den = {dsum, 1'b0};
    end

    // ---------------- stage 4: magnitudes, dividends, overflow check
    dstage_t       dv_reg [0:QB];
    logic [QB:0]   dv_vld_reg;
    dstage_t       dv0_next;
    logic          dneg, nxneg, nyneg;
    logic [DW-1:0] dmag;
    logic [NW-1:0] nxmag, nymag;
    logic [MW-1:0] mx, my;
    logic [HW-1:0] hx, hy;

    always_comb
    begin
        dneg  = s3_reg.den[DW-1];
        nxneg = s3_reg.nx[NW-1];
        nyneg = s3_reg.ny[NW-1];
        dmag  = dneg  ? (~s3_reg.den + 1'b1) : s3_reg.den;
        nxmag = nxneg ? (~s3_reg.nx + 1'b1)  : s3_reg.nx;
        nymag = nyneg ? (~s3_reg.ny + 1'b1)  : s3_reg.ny;
        mx    = (MW'(nxmag) << (FRAC_BITS + 1)) + MW'(dmag);
        my    = (MW'(nymag) << (FRAC_BITS + 1)) + MW'(dmag);
        hx    = HW'(mx >> QB);
        hy    = HW'(my >> QB);
        dv0_next.zero = (s3_reg.den == '0);
        dv0_next.dvs  = {dmag, 1'b0};
        dv0_next.ovfx = (CW'(hx) >= CW'(dv0_next.dvs));
        dv0_next.ovfy = (CW'(hy) >= CW'(dv0_next.dvs));
        dv0_next.rx   = VW'(hx);
        dv0_next.ry   = VW'(hy);
        dv0_next.wx   = QB'(mx);
        dv0_next.wy   = QB'(my);
        dv0_next.negx = nxneg ^ dneg;
        dv0_next.negy = nyneg ^ dneg;
    end

    // ---------------- final stage: sign, clamp, status
    res_t fin_reg, fin_next;
    logic fin_vld_reg;
    logic satx, saty;

    always_comb
    begin
        fin_next.cxo = finish(dv_reg[QB].wx, dv_reg[QB].negx, dv_reg[QB].ovfx, satx);
        fin_next.cyo = finish(dv_reg[QB].wy, dv_reg[QB].negy, dv_reg[QB].ovfy, saty);
        if (dv_reg[QB].zero)
        begin
            fin_next.cxo = '0;
            fin_next.cyo = '0;
            fin_next.st  = tcc_pkg::STAT_COLLINEAR;
        end
        else if (satx || saty)
            fin_next.st = tcc_pkg::STAT_SAT;
        else
            fin_next.st = tcc_pkg::STAT_OK;
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            fin_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            in_vld_reg  <= s_tvalid;
            s1_vld_reg  <= in_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            dv_vld_reg  <= {dv_vld_reg[QB-1:0], s3_vld_reg};
            fin_vld_reg <= dv_vld_reg[QB];
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            in_reg    <= in_next;
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            s3_reg    <= s3_next;
            dv_reg[0] <= dv0_next;
            for (int i = 0; i < QB; i++)
                dv_reg[i+1] <= div_step(dv_reg[i]);
            fin_reg   <= fin_next;
        end
    end

    // ---------------- output register and skid register
    res_t out_reg, skid_reg;
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
                skid_valid_reg <= 1'b0;
        end
        else if (fin_vld_reg)
        begin
            if (!out_valid_reg || m_tready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
                out_reg <= skid_reg;
        end
        else if (fin_vld_reg)
        begin
            if (!out_valid_reg || m_tready)
                out_reg <= fin_reg;
            else
                skid_reg <= fin_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.cyo, out_reg.cxo};
    assign m_tuser  = out_reg.st;

endmodule
